// ===== design/tpmmq_pkg.sv =====
`default_nettype none

package tpmmq_pkg;

  // Node numbers and depths arrive as 10-bit fields, so the tables hold exactly 1024 entries.
  localparam int unsigned NodeBits   = 10;
  localparam int unsigned Nodes      = 1 << NodeBits;
  localparam int unsigned WeightBits = 32;

  // A walk stops after twice as many steps as there are nodes.
  localparam int unsigned StepLimit  = 2 * Nodes;
  localparam int unsigned StepBits   = $clog2(StepLimit + 1);

  typedef logic [NodeBits-1:0]   node_t;
  typedef logic [WeightBits-1:0] weight_t;
  typedef logic [StepBits-1:0]   step_t;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdQuery = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StEval
  } state_e;

  typedef enum logic {
    PhJump,
    PhWalk
  } phase_e;

  typedef struct packed {
    node_t   parent;
    node_t   depth;
    weight_t weight;
    node_t   jump;
    logic    marked;
    weight_t jump_min;
    weight_t jump_max;
  } node_entry_t;

endpackage

`default_nettype wire

// ===== design/tpmmq_if.sv =====
`default_nettype none

interface tpmmq_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  tpmmq_pkg::node_t         node;
  tpmmq_pkg::node_t         other_node;
  tpmmq_pkg::node_t         parent_node;
  tpmmq_pkg::node_t         node_depth;
  tpmmq_pkg::weight_t       edge_weight;
  tpmmq_pkg::node_t         jump_target;
  logic                     jump_marked;
  tpmmq_pkg::weight_t       jump_min;
  tpmmq_pkg::weight_t       jump_max;

  modport source (
    output valid, command, node, other_node, parent_node, node_depth, edge_weight,
           jump_target, jump_marked, jump_min, jump_max,
    input  ready
  );

  modport sink (
    input  valid, command, node, other_node, parent_node, node_depth, edge_weight,
           jump_target, jump_marked, jump_min, jump_max,
    output ready
  );
endinterface

interface tpmmq_out_if;
  logic                     valid;
  logic                     ready;
  tpmmq_pkg::weight_t       path_min;
  tpmmq_pkg::weight_t       path_max;
  logic                     path_empty;
  logic                     walk_fault;

  modport source (
    output valid, path_min, path_max, path_empty, walk_fault,
    input  ready
  );

  modport sink (
    input  valid, path_min, path_max, path_empty, walk_fault,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/tree_path_min_max_query.sv =====
// Path min/max edge query over a rooted tree stored in a node memory.
// Input channel in_i carries two kinds of item. A load item writes one node entry
// (parent, depth, edge weight, block jump target, jump mark, jump min and max) and
// produces no result. A query item names two nodes and produces one result item on
// out_o: the min and max edge weight on the path between them, an empty flag when
// both nodes are the same, and a fault flag when the walk runs past 2048 steps.
// Entries must be loaded before a query reads them.
// A load is written into the node memory when it is accepted. A query climbs in steps
// (jumps plus single edges), then the result sits in the output register. Each step
// reads both current nodes from the dual-read node memory and evaluates them in the
// next cycle. One item is handled at a time; a new item is taken as soon as the
// previous one has finished, even if its result has not yet been taken. A finished
// query waits while the output register is still full.
// Reset clears the control state and empties the output register; the node memory
// is not cleared and holds garbage until loaded.
`default_nettype none

module tree_path_min_max_query (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tpmmq_in_if.sink    in_i,
  tpmmq_out_if.source out_o
);
  import tpmmq_pkg::*;

  node_entry_t mem [Nodes];
  node_entry_t rd_a_q, rd_b_q;

  state_e  state_q, state_d;
  phase_e  phase_q, phase_d;
  node_t   a_q, a_d, b_q, b_d;
  step_t   steps_q, steps_d;
  logic    have_q, have_d;
  weight_t min_q, min_d, max_q, max_d;

  logic    out_valid_q, out_valid_d;
  weight_t out_min_q, out_min_d, out_max_q, out_max_d;
  logic    out_empty_q, out_empty_d, out_fault_q, out_fault_d;

  logic        in_fire;
  logic        slot_free;
  logic        pick_a;
  node_entry_t ent_c;
  logic        use_jump, need_step, at_limit;
  weight_t     lo, hi;
  node_t       next_c;
  node_entry_t wr_entry;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;

  assign wr_entry = '{
    parent:   in_i.parent_node,
    depth:    in_i.node_depth,
    weight:   in_i.edge_weight,
    jump:     in_i.jump_target,
    marked:   in_i.jump_marked,
    jump_min: in_i.jump_min,
    jump_max: in_i.jump_max
  };

  always_ff @(posedge clk_i) begin
    if (in_fire && (in_i.command == CmdLoad)) begin
      mem[in_i.node] <= wr_entry;
    end
  end

  // Both current nodes are read every cycle; the data is valid in the cycle after READ.
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[a_q];
    rd_b_q <= mem[b_q];
  end

  // One climbing step: the deeper node climbs, the second one on equal depth.
  always_comb begin
    pick_a    = rd_a_q.depth > rd_b_q.depth;
    ent_c     = pick_a ? rd_a_q : rd_b_q;
    // Equal nodes finish at once, so their memory data is never looked at.
    need_step = (a_q != b_q);
    use_jump  = need_step && (phase_q == PhJump) && (rd_a_q.jump != rd_b_q.jump);
    at_limit  = steps_q >= step_t'(StepLimit);
    if (use_jump && ent_c.marked) begin
      lo     = ent_c.jump_min;
      hi     = ent_c.jump_max;
      next_c = ent_c.jump;
    end else begin
      lo     = ent_c.weight;
      hi     = ent_c.weight;
      next_c = ent_c.parent;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    a_d         = a_q;
    b_d         = b_q;
    steps_d     = steps_q;
    have_d      = have_q;
    min_d       = min_q;
    max_d       = max_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_min_d   = out_min_q;
    out_max_d   = out_max_q;
    out_empty_d = out_empty_q;
    out_fault_d = out_fault_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire && (in_i.command == CmdQuery)) begin
          a_d     = in_i.node;
          b_d     = in_i.other_node;
          phase_d = PhJump;
          steps_d = '0;
          have_d  = 1'b0;
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StEval;
      end
      StEval: begin
        if (!need_step || at_limit) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_fault_d = need_step;
            // Only a query whose two nodes coincide finishes without any step.
            out_empty_d = !need_step && !have_q;
            out_min_d   = (need_step || !have_q) ? '0 : min_q;
            out_max_d   = (need_step || !have_q) ? '0 : max_q;
            state_d     = StIdle;
          end
        end else begin
          steps_d = steps_q + step_t'(1);
          have_d  = 1'b1;
          min_d   = (!have_q || (lo < min_q)) ? lo : min_q;
          max_d   = (!have_q || (hi > max_q)) ? hi : max_q;
          phase_d = use_jump ? PhJump : PhWalk;
          if (pick_a) begin
            a_d = next_c;
          end else begin
            b_d = next_c;
          end
          state_d = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhJump;
      steps_q     <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      steps_q     <= steps_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    min_q       <= min_d;
    max_q       <= max_d;
    out_min_q   <= out_min_d;
    out_max_q   <= out_max_d;
    out_empty_q <= out_empty_d;
    out_fault_q <= out_fault_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.path_min   = out_min_q;
  assign out_o.path_max   = out_max_q;
  assign out_o.path_empty = out_empty_q;
  assign out_o.walk_fault = out_fault_q;

  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= step_t'(StepLimit))
    else $error("step counter ran past its limit");

  a_have_tracks_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (have_q == (steps_q != '0)))
    else $error("running min/max flag out of step with the step counter");

  a_query_starts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.command == CmdQuery)) |=>
      ((state_q == StRead) && (steps_q == '0) && (phase_q == PhJump)))
    else $error("query did not start from a clean walk state");

  a_empty_not_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_empty_q && out_fault_q))
    else $error("result flagged both empty and faulted");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_empty_q || out_fault_q)) |-> ((out_min_q == '0) && (out_max_q == '0)))
    else $error("empty or faulted result carries a nonzero weight");

endmodule

`default_nettype wire

// ===== bench/tree_path_min_max_query_test.sv =====
module tree_path_min_max_query_test;
  import tpmmq_pkg::*;

  localparam int unsigned DirectedRows = 21;
  localparam int unsigned RandomItems  = 500;
  localparam int unsigned CycleLimit   = 8_000_000;

  typedef struct packed {
    cmd_e    cmd;
    node_t   node;
    node_t   other;
    node_t   parent;
    node_t   depth;
    weight_t weight;
    node_t   jump;
    logic    marked;
    weight_t jmin;
    weight_t jmax;
  } tree_item_t;

  typedef struct packed {
    weight_t pmin;
    weight_t pmax;
    logic    empty;
    logic    fault;
  } path_result_t;

  typedef struct packed {
    tree_item_t   item;
    logic         known;
    path_result_t answer;
  } dir_row_t;

  typedef enum logic [1:0] {
    RxAlways,
    RxPattern,
    RxRandom
  } stall_mode_e;

  localparam path_result_t EmptyPath = '{pmin: '0, pmax: '0, empty: 1'b1, fault: 1'b0};
  localparam path_result_t FaultPath = '{pmin: '0, pmax: '0, empty: 1'b0, fault: 1'b1};
  localparam path_result_t TopPath   = '{pmin: '1, pmax: '1, empty: 1'b0, fault: 1'b0};
  localparam path_result_t SpanPath  = '{pmin: '0, pmax: '1, empty: 1'b0, fault: 1'b0};

  logic clk_i;
  logic rst_ni;

  tpmmq_in_if  req_if ();
  tpmmq_out_if rsp_if ();

  tree_path_min_max_query DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  node_entry_t  node_mem [Nodes];
  path_result_t pending_paths [$];
  dir_row_t     directed_rows [DirectedRows];
  int unsigned  mismatch_count;
  int unsigned  items_sent;
  int unsigned  burst_left;
  int unsigned  cycle_count;
  path_result_t seen_path;
  path_result_t due_path;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void store_entry(tree_item_t it);
    node_mem[it.node].parent   = it.parent;
    node_mem[it.node].depth    = it.depth;
    node_mem[it.node].weight   = it.weight;
    node_mem[it.node].jump     = it.jump;
    node_mem[it.node].marked   = it.marked;
    node_mem[it.node].jump_min = it.jmin;
    node_mem[it.node].jump_max = it.jmax;
  endfunction

  // Climbs the deeper node (the second one on a tie), first by block jumps until both
  // share a jump target, then by single edges until the two nodes meet.
  function automatic path_result_t walk_path(node_t a, node_t b);
    path_result_t res;
    int unsigned  steps;
    logic         jumping;
    logic         seen;
    logic         take_a;
    node_t        hop;
    node_t        nxt;
    weight_t      lo;
    weight_t      hi;
    weight_t      mn;
    weight_t      mx;
    res     = '0;
    steps   = 0;
    jumping = 1'b1;
    seen    = 1'b0;
    mn      = '0;
    mx      = '0;
    if (a == b) begin
      res.empty = 1'b1;
      return res;
    end
    while (1'b1) begin
      if (jumping && node_mem[a].jump == node_mem[b].jump) jumping = 1'b0;
      if (!jumping && a == b) break;
      if (steps >= StepLimit) begin
        res.fault = 1'b1;
        break;
      end
      steps++;
      take_a = node_mem[a].depth > node_mem[b].depth;
      hop = take_a ? a : b;
      if (jumping && node_mem[hop].marked) begin
        lo  = node_mem[hop].jump_min;
        hi  = node_mem[hop].jump_max;
        nxt = node_mem[hop].jump;
      end else begin
        lo  = node_mem[hop].weight;
        hi  = node_mem[hop].weight;
        nxt = node_mem[hop].parent;
      end
      if (!seen || lo < mn) mn = lo;
      if (!seen || hi > mx) mx = hi;
      seen = 1'b1;
      if (take_a) a = nxt;
      else b = nxt;
    end
    if (!res.fault && seen) begin
      res.pmin = mn;
      res.pmax = mx;
    end
    return res;
  endfunction

  function automatic dir_row_t entry_row(node_t n, node_t par, node_t dep, weight_t w,
                                         node_t jmp, logic mk, weight_t lo, weight_t hi);
    dir_row_t r;
    r = '0;
    r.item.cmd    = CmdLoad;
    r.item.node   = n;
    r.item.other  = ~n;
    r.item.parent = par;
    r.item.depth  = dep;
    r.item.weight = w;
    r.item.jump   = jmp;
    r.item.marked = mk;
    r.item.jmin   = lo;
    r.item.jmax   = hi;
    return r;
  endfunction

  function automatic dir_row_t query_row(node_t a, node_t b, logic known, path_result_t ans);
    dir_row_t r;
    r = '0;
    r.item.cmd   = CmdQuery;
    r.item.node  = a;
    r.item.other = b;
    r.known      = known;
    r.answer     = ans;
    return r;
  endfunction

  function automatic tree_item_t random_item();
    tree_item_t it;
    it.cmd    = cmd_e'($urandom_range(0, 1));
    it.node   = node_t'($urandom);
    it.other  = node_t'($urandom);
    it.parent = node_t'($urandom);
    it.depth  = node_t'($urandom);
    it.weight = weight_t'($urandom);
    it.jump   = node_t'($urandom);
    it.marked = 1'($urandom_range(0, 1));
    it.jmin   = weight_t'($urandom);
    it.jmax   = weight_t'($urandom);
    return it;
  endfunction

  // A spread of zero draws over the full weight range; a small spread forces ties.
  function automatic weight_t pick_weight(int unsigned spread);
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return (spread == 0) ? weight_t'($urandom) : weight_t'($urandom_range(0, spread));
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // The sender works in bursts; the expectation is recorded on the cycle before the
  // accepting edge, so it is queued in input order.
  task automatic push_item(input tree_item_t it, input logic known, input path_result_t answer);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(posedge clk_i);
        req_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(posedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.command     <= it.cmd;
    req_if.node        <= it.node;
    req_if.other_node  <= it.other;
    req_if.parent_node <= it.parent;
    req_if.node_depth  <= it.depth;
    req_if.edge_weight <= it.weight;
    req_if.jump_target <= it.jump;
    req_if.jump_marked <= it.marked;
    req_if.jump_min    <= it.jmin;
    req_if.jump_max    <= it.jmax;
    do @(negedge clk_i); while (req_if.ready !== 1'b1);
    items_sent++;
    if (it.cmd == CmdLoad) store_entry(it);
    else pending_paths.insert(pending_paths.size(),
                              known ? answer : walk_path(it.node, it.other));
  endtask

  task automatic drain_paths();
    @(posedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_paths.size() != 0) @(negedge clk_i);
  endtask

  // Builds a tree on distinct node numbers, loads it in shuffled order and then queries
  // paths inside it. A broken tree gets random jump pointers, which may loop.
  task automatic run_tree_phase(input int unsigned size, input logic broken,
                                input int unsigned queries, input int unsigned spread);
    node_t       ids [$];
    int          up [$];
    int unsigned lvl [$];
    weight_t     wt [$];
    int          order [$];
    bit          taken [Nodes];
    int unsigned blk;
    int unsigned tgt;
    int          j;
    int          k;
    node_t       pick;
    weight_t     lo;
    weight_t     hi;
    tree_item_t  it;
    blk = $urandom_range(1, 6);
    for (int i = 0; i < int'(size); i++) begin
      do pick = node_t'($urandom_range(0, Nodes - 1)); while (taken[pick]);
      taken[pick] = 1'b1;
      ids.insert(ids.size(), pick);
      if (i == 0) begin
        up.insert(up.size(), 0);
        lvl.insert(lvl.size(), 0);
      end else begin
        // Half the nodes extend the newest branch, which keeps the tree deep.
        k = ($urandom_range(0, 1) == 0) ? i - 1 : $urandom_range(0, i - 1);
        up.insert(up.size(), k);
        lvl.insert(lvl.size(), lvl[k] + 1);
      end
      wt.insert(wt.size(), pick_weight(spread));
      order.insert(order.size(), i);
    end
    for (int i = int'(size) - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      k = order[i];
      order[i] = order[j];
      order[j] = k;
    end
    foreach (order[n]) begin
      j = order[n];
      it = random_item();
      it.cmd    = CmdLoad;
      it.node   = ids[j];
      it.parent = ids[up[j]];
      it.depth  = node_t'(lvl[j]);
      it.weight = wt[j];
      if (broken) begin
        it.jump = ids[$urandom_range(0, size - 1)];
      end else if (lvl[j] == 0) begin
        it.jump = ids[j];
      end else begin
        // The jump leads to the nearest proper ancestor whose depth is a multiple of the block size.
        tgt = blk * ((lvl[j] - 1) / blk);
        k = j;
        lo = '1;
        hi = '0;
        while (lvl[k] > tgt) begin
          if (wt[k] < lo) lo = wt[k];
          if (wt[k] > hi) hi = wt[k];
          k = up[k];
        end
        it.jump   = ids[k];
        it.marked = ($urandom_range(0, 3) != 0);
        it.jmin   = lo;
        it.jmax   = hi;
      end
      push_item(it, 1'b0, '0);
    end
    repeat (queries) begin
      it = random_item();
      it.cmd  = CmdQuery;
      it.node = ids[$urandom_range(0, size - 1)];
      case ($urandom_range(0, 9))
        0: it.other = it.node;
        1: it.other = it.node;
        2: begin
          // Same node anywhere in the tables: an empty path reads nothing.
          it.node  = node_t'($urandom);
          it.other = it.node;
        end
        default: it.other = ids[$urandom_range(0, size - 1)];
      endcase
      push_item(it, 1'b0, '0);
    end
  endtask

  initial begin
    stall_mode_e mode;
    int unsigned mode_left;
    logic [12:0] pattern;
    mode_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 200);
        pattern = 13'($urandom) | 13'd1;
      end
      mode_left--;
      case (mode)
        RxAlways: rsp_if.ready <= 1'b1;
        RxPattern: begin
          rsp_if.ready <= pattern[0];
          pattern = {pattern[0], pattern[12:1]};
        end
        default: rsp_if.ready <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      seen_path = {rsp_if.path_min, rsp_if.path_max, rsp_if.path_empty, rsp_if.walk_fault};
      if (pending_paths.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, got min %0h max %0h empty %0b fault %0b",
                 $time, seen_path.pmin, seen_path.pmax, seen_path.empty, seen_path.fault);
      end else begin
        due_path = pending_paths.pop_front();
        compare_field("path_min", due_path.pmin, seen_path.pmin);
        compare_field("path_max", due_path.pmax, seen_path.pmax);
        compare_field("path_empty", 32'(due_path.empty), 32'(seen_path.empty));
        compare_field("walk_fault", 32'(due_path.fault), 32'(seen_path.fault));
      end
    end
  end

  initial begin
    int unsigned phase;
    mismatch_count = 0;
    items_sent     = 0;
    burst_left     = 0;
    cycle_count    = 0;
    phase          = 0;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.command     <= CmdLoad;
    req_if.node        <= '0;
    req_if.other_node  <= '0;
    req_if.parent_node <= '0;
    req_if.node_depth  <= '0;
    req_if.edge_weight <= '0;
    req_if.jump_target <= '0;
    req_if.jump_marked <= 1'b0;
    req_if.jump_min    <= '0;
    req_if.jump_max    <= '0;

    directed_rows = '{
      query_row(0, 0, 1'b1, EmptyPath),
      query_row(1023, 1023, 1'b1, EmptyPath),
      entry_row(0, 0, 0, '0, 0, 1'b0, '0, '0),
      entry_row(1023, 0, 1, '1, 0, 1'b1, '1, '1),
      entry_row(5, 1023, 2, 7, 0, 1'b1, 7, '1),
      entry_row(6, 0, 1, 100, 0, 1'b0, '0, '0),
      entry_row(7, 0, 1, '0, 0, 1'b0, '0, '0),
      query_row(1023, 0, 1'b1, TopPath),
      query_row(0, 1023, 1'b1, TopPath),
      query_row(5, 6, 1'b0, '0),
      query_row(6, 5, 1'b0, '0),
      query_row(5, 1023, 1'b0, '0),
      query_row(7, 1023, 1'b1, SpanPath),
      // All-ones entry whose marked jump lands straight on the other node.
      entry_row(1023 - 723, 1023, 1023, '1, 1023, 1'b1, '1, '1),
      query_row(1023 - 723, 1023, 1'b1, TopPath),
      query_row(6, 1023 - 723, 1'b0, '0),
      // Two separate self-rooted nodes never meet, so the walk runs out of steps.
      entry_row(100, 100, 0, 1, 100, 1'b0, '0, '0),
      entry_row(200, 200, 0, 2, 200, 1'b1, 3, 4),
      query_row(100, 200, 1'b1, FaultPath),
      query_row(5, 5, 1'b1, EmptyPath),
      query_row(200, 100, 1'b1, FaultPath)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      push_item(directed_rows[r].item, directed_rows[r].known, directed_rows[r].answer);
    end

    while (items_sent < DirectedRows + RandomItems) begin
      phase++;
      if (phase == 2 || $urandom_range(0, 3) == 0) drain_paths();
      if (phase % 6 == 4) begin
        run_tree_phase($urandom_range(4, 10), 1'b1, $urandom_range(4, 8), 0);
      end else if (phase % 9 == 7) begin
        run_tree_phase($urandom_range(100, 140), 1'b0, 16, 0);
      end else begin
        run_tree_phase($urandom_range(4, 40), 1'b0, $urandom_range(8, 40),
                       (phase % 2 == 1) ? 0 : 15);
      end
    end

    @(posedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_paths.size() != 0) @(negedge clk_i);
    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tpmmq_pkg.sv
design/tpmmq_if.sv
design/tree_path_min_max_query.sv
bench/tree_path_min_max_query_test.sv
